@@ src/sbs_pkg.sv @@
// Shared types and codes for the sorted bookmark set.
package sbs_pkg;

    localparam int OP_W  = 4;
    localparam int CHG_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TOGGLE     = 4'd0,
        OP_ADD        = 4'd1,
        OP_REMOVE     = 4'd2,
        OP_NEXT       = 4'd3,
        OP_PREV       = 4'd4,
        OP_TRIM       = 4'd5,
        OP_LIST       = 4'd6,
        OP_CLEAR      = 4'd7,
        OP_SET_EN     = 4'd8,
        OP_TOGGLE_EN  = 4'd9
    } opcode_t;

    localparam logic [CHG_W-1:0] CHG_NONE    = 2'd0;
    localparam logic [CHG_W-1:0] CHG_ADDED   = 2'd1;
    localparam logic [CHG_W-1:0] CHG_REMOVED = 2'd2;
    localparam logic [CHG_W-1:0] CHG_ENABLE  = 2'd3;

    typedef enum logic [1:0] {
        MODE_FIND,
        MODE_DEL_EQ,
        MODE_TRIM,
        MODE_LIST
    } mode_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_IDX,
        SRC_NEXT,
        SRC_PREV
    } src_t;

    typedef struct packed {
        logic             load_op;
        logic             asc_step;
        mode_t            mode;
        logic             desc_init;
        logic             desc_step;
        logic             cnt_commit;
        logic             cnt_inc;
        logic             cnt_clear;
        logic             en_set;
        logic             en_flip;
        logic             emit_rd;
        logic             out_ld;
        logic             out_from_rem;
        logic             success;
        logic [CHG_W-1:0] change;
        logic             full;
        src_t             src;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic asc_done;
        logic desc_done;
        logic hit;
        logic full;
        logic rem_none;
        logic emit_last;
        logic out_free;
        logic en_differs;
    } status_t;

endpackage

@@ src/sorted_bookmark_set.sv @@
// Top level of the sorted bookmark set: controller, datapath and stream ports.
//
// One operation word is taken at a time; s_tready is high only while the block is idle.
// Every operation except clear, set-enable and toggle-enable scans the point table once at
// one entry per cycle through the table memory's single read port, an insert adds a
// downward shift pass, and each result word of list or trim is read back through the
// removal buffer memory in a read state and a load state. Loading a result waits for
// m_tready while the output register still holds an unaccepted word. A finished word
// waits in the output register while the next operation is accepted. No clearing pass is
// needed after reset.
module sorted_bookmark_set #(
    parameter int  MAX_POINTS  = 64,
    parameter int  INDEX_WIDTH = 16,
    localparam int CW          = $clog2(MAX_POINTS + 1),
    localparam int IN_W        = ((2 * INDEX_WIDTH + 1 + 7) / 8) * 8,
    localparam int OUT_W       = ((5 + INDEX_WIDTH + CW + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_W-1:0]          s_tdata,   // index, end_index, enable_value
    input  logic [sbs_pkg::OP_W-1:0] s_tuser,   // opcode
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_W-1:0]         m_tdata,   // success, index_out, change, enabled, full_res, count
    output logic                     m_tlast
);

    sbs_pkg::cmd_t    cmd;
    sbs_pkg::status_t status;

    sbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    sbs_datapath #(
        .MAX_POINTS  (MAX_POINTS),
        .INDEX_WIDTH (INDEX_WIDTH),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ src/sbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/sbs_ctrl.sv @@
// Controller state machine for the sorted bookmark set.
module sbs_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [sbs_pkg::OP_W-1:0] s_tuser,
    input  sbs_pkg::status_t        status,
    output sbs_pkg::cmd_t           cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ASC,
        S_DESC,
        S_APPLY,
        S_RESP,
        S_EM_RD,
        S_EM_LD
    } state_t;

    state_t                        state_reg, state_next;
    logic [sbs_pkg::OP_W-1:0]      op_reg, op_next;
    logic                          rsp_success_reg, rsp_success_next;
    logic [sbs_pkg::CHG_W-1:0]     rsp_change_reg, rsp_change_next;
    logic                          rsp_full_reg, rsp_full_next;
    sbs_pkg::src_t                 rsp_src_reg, rsp_src_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= '0;
            rsp_success_reg <= 1'b0;
            rsp_change_reg  <= sbs_pkg::CHG_NONE;
            rsp_full_reg    <= 1'b0;
            rsp_src_reg     <= sbs_pkg::SRC_ZERO;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            rsp_success_reg <= rsp_success_next;
            rsp_change_reg  <= rsp_change_next;
            rsp_full_reg    <= rsp_full_next;
            rsp_src_reg     <= rsp_src_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        rsp_success_next = rsp_success_reg;
        rsp_change_next  = rsp_change_reg;
        rsp_full_next    = rsp_full_reg;
        rsp_src_next     = rsp_src_reg;
        cmd              = '0;
        cmd.mode         = sbs_pkg::MODE_FIND;
        cmd.src          = sbs_pkg::SRC_ZERO;
        cmd.change       = sbs_pkg::CHG_NONE;

        case (op_reg)
            sbs_pkg::OP_TOGGLE, sbs_pkg::OP_REMOVE: cmd.mode = sbs_pkg::MODE_DEL_EQ;
            sbs_pkg::OP_TRIM:                       cmd.mode = sbs_pkg::MODE_TRIM;
            sbs_pkg::OP_LIST:                       cmd.mode = sbs_pkg::MODE_LIST;
            default:                                cmd.mode = sbs_pkg::MODE_FIND;
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_op = 1'b1;
                    op_next     = s_tuser;
                    case (s_tuser)
                        sbs_pkg::OP_TOGGLE, sbs_pkg::OP_ADD, sbs_pkg::OP_REMOVE,
                        sbs_pkg::OP_NEXT, sbs_pkg::OP_PREV, sbs_pkg::OP_TRIM,
                        sbs_pkg::OP_LIST: state_next = S_ASC;
                        default:          state_next = S_APPLY;
                    endcase
                end
            end
            S_ASC:
            begin
                cmd.asc_step = 1'b1;
                if (status.asc_done)
                begin
                    rsp_success_next = 1'b0;
                    rsp_change_next  = sbs_pkg::CHG_NONE;
                    rsp_full_next    = 1'b0;
                    rsp_src_next     = sbs_pkg::SRC_IDX;
                    state_next       = S_RESP;
                    case (op_reg)
                        sbs_pkg::OP_TOGGLE, sbs_pkg::OP_ADD:
                        begin
                            cmd.cnt_commit = (op_reg == sbs_pkg::OP_TOGGLE);
                            if (status.hit)
                            begin
                                if (op_reg == sbs_pkg::OP_TOGGLE)
                                begin
                                    rsp_change_next = sbs_pkg::CHG_REMOVED;
                                end
                            end
                            else if (status.full)
                            begin
                                rsp_full_next = 1'b1;
                            end
                            else
                            begin
                                rsp_success_next = 1'b1;
                                rsp_change_next  = sbs_pkg::CHG_ADDED;
                                cmd.desc_init    = 1'b1;
                                state_next       = S_DESC;
                            end
                        end
                        sbs_pkg::OP_REMOVE:
                        begin
                            cmd.cnt_commit = 1'b1;
                            if (status.hit)
                            begin
                                rsp_success_next = 1'b1;
                                rsp_change_next  = sbs_pkg::CHG_REMOVED;
                            end
                        end
                        sbs_pkg::OP_NEXT: rsp_src_next = sbs_pkg::SRC_NEXT;
                        sbs_pkg::OP_PREV: rsp_src_next = sbs_pkg::SRC_PREV;
                        default:
                        begin
                            cmd.cnt_commit = (op_reg == sbs_pkg::OP_TRIM);
                            rsp_src_next   = sbs_pkg::SRC_ZERO;
                            if (!status.rem_none)
                            begin
                                state_next = S_EM_RD;
                            end
                        end
                    endcase
                end
            end
            S_DESC:
            begin
                cmd.desc_step = 1'b1;
                if (status.desc_done)
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_APPLY:
            begin
                rsp_success_next = 1'b0;
                rsp_change_next  = sbs_pkg::CHG_NONE;
                rsp_full_next    = 1'b0;
                rsp_src_next     = sbs_pkg::SRC_ZERO;
                state_next       = S_RESP;
                case (op_reg)
                    sbs_pkg::OP_CLEAR: cmd.cnt_clear = 1'b1;
                    sbs_pkg::OP_SET_EN:
                    begin
                        if (status.en_differs)
                        begin
                            cmd.en_set      = 1'b1;
                            rsp_change_next = sbs_pkg::CHG_ENABLE;
                        end
                    end
                    sbs_pkg::OP_TOGGLE_EN:
                    begin
                        cmd.en_flip     = 1'b1;
                        rsp_change_next = sbs_pkg::CHG_ENABLE;
                    end
                    default: rsp_src_next = sbs_pkg::SRC_ZERO;
                endcase
            end
            S_RESP:
            begin
                cmd.success = rsp_success_reg;
                cmd.change  = rsp_change_reg;
                cmd.full    = rsp_full_reg;
                cmd.src     = rsp_src_reg;
                cmd.last    = 1'b1;
                if (status.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EM_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EM_LD;
            end
            S_EM_LD:
            begin
                cmd.out_from_rem = 1'b1;
                cmd.change       = (op_reg == sbs_pkg::OP_TRIM) ? sbs_pkg::CHG_REMOVED
                                                                : sbs_pkg::CHG_NONE;
                cmd.last         = status.emit_last;
                if (status.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = status.emit_last ? S_IDLE : S_EM_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ src/sbs_datapath.sv @@
// Datapath: point table, removal buffer, scan and shift counters, output register.
module sbs_datapath #(
    parameter int MAX_POINTS  = 64,
    parameter int INDEX_WIDTH = 16,
    parameter int IN_W        = 40,
    parameter int OUT_W       = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IN_W-1:0]   s_tdata,
    input  sbs_pkg::cmd_t     cmd,
    output sbs_pkg::status_t  status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tlast
);

    localparam int AW      = $clog2(MAX_POINTS);
    localparam int CW      = $clog2(MAX_POINTS + 1);
    localparam int IW      = INDEX_WIDTH;

    logic [IW-1:0]  idx_reg, end_reg, idx_next, end_next;
    logic           ev_reg, ev_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           en_reg, en_next;
    logic [CW-1:0]  a_reg, a_next, w_reg, w_next, r_reg, r_next, e_reg, e_next;
    logic [AW-1:0]  dpos_reg, dpos_next;
    logic           rv_reg, rv_next, stop_reg, stop_next;
    logic           hit_reg, hit_next, seen_reg, seen_next;
    logic           nfound_reg, nfound_next, pfound_reg, pfound_next;
    logic [IW-1:0]  first_reg, first_next, lastd_reg, lastd_next;
    logic [IW-1:0]  nans_reg, nans_next, pans_reg, pans_next;

    logic           mv_reg, mv_next;
    logic           o_success_reg, o_success_next, o_full_reg, o_full_next;
    logic           o_en_reg, o_en_next, o_last_reg, o_last_next;
    logic [IW-1:0]  o_idx_reg, o_idx_next;
    logic [1:0]     o_change_reg, o_change_next;
    logic [CW-1:0]  o_count_reg, o_count_next;

    logic           tbl_we, tbl_re, rem_we;
    logic [AW-1:0]  tbl_waddr, tbl_raddr, rem_waddr;
    logic [IW-1:0]  tbl_wdata, tbl_rdata, rem_rdata, d, sel_idx;
    logic [CW-1:0]  a_m1;
    logic           eq, outside, del;

    sbs_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    sbs_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_removed (
        .clk   (clk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (d),
        .re    (cmd.emit_rd),
        .raddr (e_reg[AW-1:0]),
        .rdata (rem_rdata)
    );

    assign d       = tbl_rdata;
    assign a_m1    = a_reg - 1'b1;
    assign eq      = (d == idx_reg);
    assign outside = (idx_reg < end_reg) ? ((d < idx_reg) || (d > end_reg))
                                         : ((d < idx_reg) && (d > end_reg));
    assign del     = ((cmd.mode == sbs_pkg::MODE_DEL_EQ) && eq)
                   || ((cmd.mode == sbs_pkg::MODE_TRIM) && outside);

    always_comb
    begin
        case (cmd.src)
            sbs_pkg::SRC_IDX:  sel_idx = idx_reg;
            sbs_pkg::SRC_NEXT: sel_idx = (count_reg == '0) ? idx_reg
                                         : (nfound_reg ? nans_reg : first_reg);
            sbs_pkg::SRC_PREV: sel_idx = (count_reg == '0) ? idx_reg
                                         : (pfound_reg ? pans_reg : lastd_reg);
            default:           sel_idx = '0;
        endcase
    end

    assign status.asc_done   = !rv_reg && (a_reg == count_reg);
    assign status.desc_done  = stop_reg;
    assign status.hit        = hit_reg;
    assign status.full       = (count_reg == CW'(MAX_POINTS));
    assign status.rem_none   = (r_reg == '0);
    assign status.emit_last  = ((e_reg + 1'b1) == r_reg);
    assign status.out_free   = !mv_reg || m_tready;
    assign status.en_differs = (ev_reg != en_reg);

    always_comb
    begin
        idx_next    = idx_reg;
        end_next    = end_reg;
        ev_next     = ev_reg;
        count_next  = count_reg;
        en_next     = en_reg;
        a_next      = a_reg;
        w_next      = w_reg;
        r_next      = r_reg;
        e_next      = e_reg;
        dpos_next   = dpos_reg;
        rv_next     = 1'b0;
        stop_next   = stop_reg;
        hit_next    = hit_reg;
        seen_next   = seen_reg;
        nfound_next = nfound_reg;
        pfound_next = pfound_reg;
        first_next  = first_reg;
        lastd_next  = lastd_reg;
        nans_next   = nans_reg;
        pans_next   = pans_reg;
        tbl_we      = 1'b0;
        tbl_waddr   = '0;
        tbl_wdata   = '0;
        tbl_re      = 1'b0;
        tbl_raddr   = '0;
        rem_we      = 1'b0;
        rem_waddr   = r_reg[AW-1:0];

        mv_next        = mv_reg && !m_tready;
        o_success_next = o_success_reg;
        o_idx_next     = o_idx_reg;
        o_change_next  = o_change_reg;
        o_en_next      = o_en_reg;
        o_full_next    = o_full_reg;
        o_count_next   = o_count_reg;
        o_last_next    = o_last_reg;

        if (cmd.load_op)
        begin
            idx_next    = s_tdata[IW-1:0];
            end_next    = s_tdata[2*IW-1:IW];
            ev_next     = s_tdata[2*IW];
            a_next      = '0;
            w_next      = '0;
            r_next      = '0;
            e_next      = '0;
            stop_next   = 1'b0;
            hit_next    = 1'b0;
            seen_next   = 1'b0;
            nfound_next = 1'b0;
            pfound_next = 1'b0;
        end

        if (cmd.desc_init)
        begin
            a_next    = count_reg;
            stop_next = 1'b0;
        end

        if (cmd.asc_step)
        begin
            if (a_reg < count_reg)
            begin
                tbl_re    = 1'b1;
                tbl_raddr = a_reg[AW-1:0];
                a_next    = a_reg + 1'b1;
                rv_next   = 1'b1;
            end
            if (rv_reg)
            begin
                hit_next   = hit_reg || eq;
                lastd_next = d;
                if (!seen_reg)
                begin
                    seen_next  = 1'b1;
                    first_next = d;
                end
                if (!nfound_reg && (d > idx_reg))
                begin
                    nfound_next = 1'b1;
                    nans_next   = d;
                end
                if (d < idx_reg)
                begin
                    pfound_next = 1'b1;
                    pans_next   = d;
                end
                if (((cmd.mode == sbs_pkg::MODE_DEL_EQ) || (cmd.mode == sbs_pkg::MODE_TRIM))
                    && !del)
                begin
                    tbl_we    = 1'b1;
                    tbl_waddr = w_reg[AW-1:0];
                    tbl_wdata = d;
                    w_next    = w_reg + 1'b1;
                end
                if (del || (cmd.mode == sbs_pkg::MODE_LIST))
                begin
                    rem_we = (cmd.mode == sbs_pkg::MODE_TRIM) || (cmd.mode == sbs_pkg::MODE_LIST);
                    if (rem_we)
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
            end
        end

        if (cmd.desc_step)
        begin
            if (!stop_reg && (a_reg != '0))
            begin
                tbl_re    = 1'b1;
                tbl_raddr = a_m1[AW-1:0];
                a_next    = a_m1;
                dpos_next = a_m1[AW-1:0];
                rv_next   = 1'b1;
            end
            if (rv_reg && !stop_reg)
            begin
                tbl_we    = 1'b1;
                tbl_waddr = dpos_reg + 1'b1;
                tbl_wdata = (d > idx_reg) ? d : idx_reg;
                stop_next = !(d > idx_reg);
            end
            else if (!stop_reg && (a_reg == '0) && !rv_reg)
            begin
                tbl_we    = 1'b1;
                tbl_waddr = '0;
                tbl_wdata = idx_reg;
                stop_next = 1'b1;
            end
        end

        if (cmd.cnt_commit)
        begin
            count_next = w_reg;
        end
        else if (cmd.cnt_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.cnt_clear)
        begin
            count_next = '0;
        end

        if (cmd.en_set)
        begin
            en_next = ev_reg;
        end
        else if (cmd.en_flip)
        begin
            en_next = ~en_reg;
        end

        if (cmd.out_ld)
        begin
            mv_next        = 1'b1;
            o_success_next = cmd.success;
            o_idx_next     = cmd.out_from_rem ? rem_rdata : sel_idx;
            o_change_next  = cmd.change;
            o_en_next      = en_reg;
            o_full_next    = cmd.full;
            o_count_next   = count_reg;
            o_last_next    = cmd.last;
            if (cmd.out_from_rem)
            begin
                e_next = e_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            en_reg    <= 1'b0;
            a_reg     <= '0;
            w_reg     <= '0;
            r_reg     <= '0;
            e_reg     <= '0;
            rv_reg    <= 1'b0;
            stop_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            nfound_reg <= 1'b0;
            pfound_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            en_reg    <= en_next;
            a_reg     <= a_next;
            w_reg     <= w_next;
            r_reg     <= r_next;
            e_reg     <= e_next;
            rv_reg    <= rv_next;
            stop_reg  <= stop_next;
            hit_reg   <= hit_next;
            seen_reg  <= seen_next;
            nfound_reg <= nfound_next;
            pfound_reg <= pfound_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        end_reg       <= end_next;
        ev_reg        <= ev_next;
        dpos_reg      <= dpos_next;
        first_reg     <= first_next;
        lastd_reg     <= lastd_next;
        nans_reg      <= nans_next;
        pans_reg      <= pans_next;
        o_success_reg <= o_success_next;
        o_idx_reg     <= o_idx_next;
        o_change_reg  <= o_change_next;
        o_en_reg      <= o_en_next;
        o_full_reg    <= o_full_next;
        o_count_reg   <= o_count_next;
        o_last_reg    <= o_last_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = OUT_W'({o_count_reg, o_full_reg, o_en_reg, o_change_reg,
                              o_idx_reg, o_success_reg});

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count above capacity");

    a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.asc_step && tbl_we) |-> (w_reg < a_reg))
        else $error("compaction write overtook scan");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.desc_step && tbl_we) |-> (count_reg < CW'(MAX_POINTS)))
        else $error("insert shift into full table");

    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_ld && cmd.out_from_rem) |-> (e_reg < r_reg))
        else $error("emit beyond buffered words");
`endif

endmodule
